// ===== sv/ps2m_pkg.sv =====
// shared types and constants for the ps/2 mouse packet decoder
package ps2m_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_X_LIMIT = 2'd1;
    localparam logic [1:0] CFG_Y_LIMIT = 2'd2;

    localparam int CFG_WIDTH = 13;

    // reset values of the registers and the largest usable limit
    localparam logic [12:0] X_LIMIT_RESET = 13'd80;
    localparam logic [12:0] Y_LIMIT_RESET = 13'd25;
    localparam logic [12:0] LIMIT_MAX     = 13'd4096;

    // byte 0 bit layout
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int XOVF_BIT  = 6;
    localparam int YOVF_BIT  = 7;

    // packet status codes
    localparam logic STATUS_UPDATED = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    localparam int TDATA_OUT_WIDTH = 48;

    typedef struct packed {
        logic              status;
        logic [11:0]       pos_x;
        logic [11:0]       pos_y;
        logic signed [8:0] delta_x;
        logic signed [8:0] delta_y;
        logic [2:0]        buttons;
    } result_t;

endpackage

// ===== sv/ps2m_in_reg.sv =====
// input register stage of the ps/2 mouse packet decoder
module ps2m_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

// ===== sv/ps2m_core.sv =====
// packet assembly, cursor update and configuration registers
module ps2m_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    output logic                  res_valid,
    output ps2m_pkg::result_t     res
);

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    logic        enable_reg;
    logic [12:0] x_limit_reg;
    logic [12:0] y_limit_reg;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [7:0]  held0_reg;
    logic [7:0]  held1_reg;
    logic [11:0] cursor_x_reg;
    logic [11:0] cursor_x_next;
    logic [11:0] cursor_y_reg;
    logic [11:0] cursor_y_next;
    logic [2:0]  buttons_reg;
    logic [2:0]  buttons_next;

    logic              overflow;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic signed [13:0] sum_x;
    logic signed [13:0] sum_y;
    logic [11:0] clamp_x;
    logic [11:0] clamp_y;

    // limit of zero acts as one, anything above 4096 saturates
    function automatic logic [11:0] clamp_axis(input logic signed [13:0] p,
                                               input logic [12:0] limit);
        logic [12:0] lim;
        logic [12:0] top;
        lim = limit;
        if (lim == 13'd0)
        begin
            lim = 13'd1;
        end
        if (lim > ps2m_pkg::LIMIT_MAX)
        begin
            lim = ps2m_pkg::LIMIT_MAX;
        end
        top = lim - 13'd1;
        if (p < 14'sd0)
        begin
            return 12'd0;
        end
        if ($unsigned(p[12:0]) >= lim)
        begin
            return top[11:0];
        end
        return p[11:0];
    endfunction

    assign overflow = held0_reg[ps2m_pkg::XOVF_BIT] || held0_reg[ps2m_pkg::YOVF_BIT];
    assign dx       = {held0_reg[ps2m_pkg::XSIGN_BIT], held1_reg};
    assign dy       = {held0_reg[ps2m_pkg::YSIGN_BIT], data_byte};
    assign sum_x    = $signed({2'b00, cursor_x_reg}) + 14'(dx);
    assign sum_y    = $signed({2'b00, cursor_y_reg}) - 14'(dy);
    assign clamp_x  = clamp_axis(sum_x, x_limit_reg);
    assign clamp_y  = clamp_axis(sum_y, y_limit_reg);

    always_comb
    begin
        pos_next      = pos_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        buttons_next  = buttons_reg;
        res_valid     = 1'b0;
        res.status    = ps2m_pkg::STATUS_UPDATED;
        res.pos_x     = cursor_x_reg;
        res.pos_y     = cursor_y_reg;
        res.delta_x   = 9'sd0;
        res.delta_y   = 9'sd0;
        res.buttons   = buttons_reg;
        if (fire && enable_reg)
        begin
            case (pos_reg)
                POS_SECOND:
                begin
                    pos_next = POS_THIRD;
                end
                POS_THIRD:
                begin
                    pos_next  = POS_FIRST;
                    res_valid = 1'b1;
                    if (overflow)
                    begin
                        res.status = ps2m_pkg::STATUS_DROPPED;
                    end
                    else
                    begin
                        cursor_x_next = clamp_x;
                        cursor_y_next = clamp_y;
                        buttons_next  = held0_reg[2:0];
                        res.pos_x     = clamp_x;
                        res.pos_y     = clamp_y;
                        res.delta_x   = dx;
                        res.delta_y   = dy;
                        res.buttons   = held0_reg[2:0];
                    end
                end
                default:
                begin
                    // wait for a first byte with the sync bit set
                    pos_next = data_byte[ps2m_pkg::SYNC_BIT] ? POS_SECOND : POS_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            x_limit_reg  <= ps2m_pkg::X_LIMIT_RESET;
            y_limit_reg  <= ps2m_pkg::Y_LIMIT_RESET;
            pos_reg      <= POS_FIRST;
            cursor_x_reg <= 12'd0;
            cursor_y_reg <= 12'd0;
            buttons_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    ps2m_pkg::CFG_ENABLE:  enable_reg  <= cfg_data[0];
                    ps2m_pkg::CFG_X_LIMIT: x_limit_reg <= cfg_data;
                    ps2m_pkg::CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                    default:               ;
                endcase
            end
            pos_reg      <= pos_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            buttons_reg  <= buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && enable_reg)
        begin
            if (pos_reg == POS_SECOND)
            begin
                held1_reg <= data_byte;
            end
            else if (pos_reg != POS_THIRD && data_byte[ps2m_pkg::SYNC_BIT])
            begin
                held0_reg <= data_byte;
            end
        end
    end

endmodule

// ===== sv/ps2m_out_reg.sv =====
// result register on the master side
module ps2m_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ps2m_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              free,
    output logic [ps2m_pkg::TDATA_OUT_WIDTH-1:0] out_data
);

    logic              valid_reg;
    logic              valid_next;
    ps2m_pkg::result_t res_reg;

    // slot can take a new result when empty or draining this cycle
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = {2'b00, res_reg.buttons, res_reg.delta_y, res_reg.delta_x,
                        res_reg.pos_y, res_reg.pos_x, res_reg.status};

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== sv/ps2_mouse_packet_decoder.sv =====
// ps/2 mouse three-byte packet decoder, top level
// Raw mouse bytes arrive on the slave stream (s_tdata[7:0]), one byte per
// transaction. Three bytes form a packet; the first must have bit 3 set.
// Each complete packet gives one transaction on the master stream with
// status, cursor position, signed deltas and buttons. Overflow packets come
// out with status 1, the cursor unchanged and zero deltas.
// Path: the byte goes into an input register and is decoded from there
// straight into the result register once that register is free, which
// raises m_tvalid.
// Throughput: one byte per cycle while the result register is free or
// draining; the add and clamp on the cursor registers are combinational.
// Configuration: cfg_wr_en with cfg_index 0 enable, 1 x limit, 2 y limit.
// Reset clears the cursor and buttons, disables the block and loads limits
// of 80 and 25. When m_tready is low with a result waiting, the input
// register takes one more byte and holds it, and s_tready stays low until
// the waiting result is taken.
module ps2_mouse_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] status, [12:1] pos_x, [24:13] pos_y, [33:25] delta_x,
    // [42:34] delta_y, [45:43] buttons, [47:46] zero
    output logic [47:0] m_tdata
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              advance;
    logic              out_free;
    logic              res_valid;
    ps2m_pkg::result_t res;

    assign advance = held_valid && out_free;

    ps2m_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    ps2m_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (advance),
        .data_byte  (held_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    ps2m_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .res        (res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .free       (out_free),
        .out_data   (m_tdata)
    );

endmodule

// ===== tb/sv/ps2_mouse_packet_decoder_checker.sv =====
// scoreboard for the ps/2 mouse packet decoder: tracks config, predicts and compares reports
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          errors,
    output int          pending
);

    logic              enabled;
    logic [12:0]       extent_x;
    logic [12:0]       extent_y;
    logic [1:0]        byte_count;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic [11:0]       cursor_x;
    logic [11:0]       cursor_y;
    logic [2:0]        button_bits;
    ps2m_pkg::result_t expected_reports[$];
    int                mismatch_count = 0;
    int                outstanding = 0;

    assign errors  = mismatch_count;
    assign pending = outstanding;

    function automatic logic [11:0] clamp_to_extent(input int pos, input logic [12:0] extent);
        int span;
        span = int'(extent);
        if (span == 0)
            span = 1;
        if (span > int'(ps2m_pkg::LIMIT_MAX))
            span = int'(ps2m_pkg::LIMIT_MAX);
        if (pos < 0)
            return 12'd0;
        if (pos >= span)
            return 12'(span - 1);
        return 12'(pos);
    endfunction

    // advance the packet assembler by one byte, queue a report when a packet completes
    task automatic decode_byte(input logic [7:0] b);
        ps2m_pkg::result_t report;
        int                dx;
        int                dy;
        if (!enabled)
            return;
        if (byte_count == 2'd1)
        begin
            second_byte = b;
            byte_count  = 2'd2;
            return;
        end
        if (byte_count != 2'd2)
        begin
            // hunt for a header byte
            if (b[ps2m_pkg::SYNC_BIT])
            begin
                first_byte = b;
                byte_count = 2'd1;
            end
            else
                byte_count = 2'd0;
            return;
        end
        byte_count = 2'd0;
        if (first_byte[ps2m_pkg::XOVF_BIT] || first_byte[ps2m_pkg::YOVF_BIT])
        begin
            report.status  = ps2m_pkg::STATUS_DROPPED;
            report.delta_x = '0;
            report.delta_y = '0;
        end
        else
        begin
            dx = int'(second_byte) - (first_byte[ps2m_pkg::XSIGN_BIT] ? 256 : 0);
            dy = int'(b) - (first_byte[ps2m_pkg::YSIGN_BIT] ? 256 : 0);
            // y grows downward on screen, mouse y grows upward
            cursor_x    = clamp_to_extent(int'(cursor_x) + dx, extent_x);
            cursor_y    = clamp_to_extent(int'(cursor_y) - dy, extent_y);
            button_bits = first_byte[2:0];
            report.status  = ps2m_pkg::STATUS_UPDATED;
            report.delta_x = 9'(dx);
            report.delta_y = 9'(dy);
        end
        report.pos_x   = cursor_x;
        report.pos_y   = cursor_y;
        report.buttons = button_bits;
        expected_reports.push_back(report);
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h",
                         $realtime, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ps2m_pkg::result_t want;
        if (!rst_n)
        begin
            enabled     = 1'b0;
            extent_x    = ps2m_pkg::X_LIMIT_RESET;
            extent_y    = ps2m_pkg::Y_LIMIT_RESET;
            byte_count  = 2'd0;
            first_byte  = '0;
            second_byte = '0;
            cursor_x    = '0;
            cursor_y    = '0;
            button_bits = '0;
            expected_reports.delete();
            outstanding = 0;
        end
        else
        begin
            // a result leaves after its last byte is taken, so compare before predicting
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: report 'h%0h with none expected", $realtime, m_tdata);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("status", int'(want.status), int'(m_tdata[0]));
                    compare_field("pos_x", int'(want.pos_x), int'(m_tdata[12:1]));
                    compare_field("pos_y", int'(want.pos_y), int'(m_tdata[24:13]));
                    compare_field("delta_x", int'($unsigned(want.delta_x)),
                                  int'(m_tdata[33:25]));
                    compare_field("delta_y", int'($unsigned(want.delta_y)),
                                  int'(m_tdata[42:34]));
                    compare_field("buttons", int'(want.buttons), int'(m_tdata[45:43]));
                    compare_field("padding", 0, int'(m_tdata[47:46]));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    ps2m_pkg::CFG_ENABLE:  enabled  = cfg_data[0];
                    ps2m_pkg::CFG_X_LIMIT: extent_x = cfg_data;
                    ps2m_pkg::CFG_Y_LIMIT: extent_y = cfg_data;
                    default:               ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            outstanding = expected_reports.size();
        end
    end

endmodule

// ===== tb/sv/ps2_mouse_packet_decoder_test.sv =====
// testbench top for the ps/2 mouse packet decoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_BYTES  = 130;
    localparam int SETTLE_DELAY = 4;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int          snd_idle;
    int          rcv_idle;
    int          hold_requests = 0;
    int          quiet_cycles = 0;
    logic [12:0] phase_x [6];
    logic [12:0] phase_y [6];

    ps2_mouse_packet_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ps2_mouse_packet_decoder_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (mismatches),
        .pending   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        m_tready     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** ps2_mouse_packet_decoder: FAILED **");
            $finish;
        end
    end

    task automatic set_idle(input int sender_pct, input int receiver_pct);
        snd_idle = sender_pct;
        rcv_idle = receiver_pct;
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
    endtask

    // drop valid, wait for every report, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_DELAY) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed packets with random content, some noise and cut-short packets
    task automatic send_random_traffic(input int n_bytes, input bit lean_x, input bit lean_y);
        int         sent;
        int         r;
        logic [7:0] head;
        sent = 0;
        while (sent < n_bytes)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_byte(8'($urandom));
                sent++;
            end
            else
            begin
                head    = 8'($urandom);
                head[3] = 1'b1;
                if ($urandom_range(4) != 0)
                    head[7:6] = 2'b00;
                // lean the sign bits so the cursor reaches the far edges
                if ($urandom_range(3) != 0)
                begin
                    head[4] = lean_x;
                    head[5] = lean_y;
                end
                send_byte(head);
                send_byte(8'($urandom));
                sent += 2;
                if (r >= 12)
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = ps2m_pkg::CFG_ENABLE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        set_idle(9, 88);
        phase_x = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd0, ps2m_pkg::X_LIMIT_RESET};
        phase_y = '{13'd4096, 13'd0, 13'd5000, 13'd1, 13'd0, ps2m_pkg::Y_LIMIT_RESET};
        phase_x[4] = 13'($urandom_range(4096, 1));
        phase_y[4] = 13'($urandom_range(4096, 1));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // disabled after reset: bytes are dropped
        send_byte(8'h2C);
        send_byte(8'h08);
        settle();
        write_reg(ps2m_pkg::CFG_ENABLE, 13'd1);
        // header hunt skips bytes without the sync bit
        send_byte(8'h00);
        send_byte(8'hF7);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h0F, 8'hFF, 8'h00);
        // cursor now beyond a lowered extent
        settle();
        write_reg(ps2m_pkg::CFG_X_LIMIT, 13'd10);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'h08, 8'h05, 8'hFF);
        send_packet(8'h4B, 8'h12, 8'h34);
        send_packet(8'h8D, 8'h56, 8'h78);
        // packet split by a disabled stretch
        send_byte(8'h09);
        send_byte(8'h10);
        settle();
        write_reg(ps2m_pkg::CFG_ENABLE, 13'd0);
        send_byte(8'hAA);
        send_byte(8'h55);
        settle();
        write_reg(ps2m_pkg::CFG_ENABLE, 13'd1);
        send_byte(8'h20);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            if (ph < 2)
                set_idle(9, 88);
            else if (ph < 4)
                set_idle(88, 9);
            else
                set_idle(0, 0);
            if (ph % 2 == 1)
            begin
                write_reg(ps2m_pkg::CFG_ENABLE, 13'd0);
                send_random_traffic(15, 1'b0, 1'b1);
                settle();
                write_reg(ps2m_pkg::CFG_ENABLE, 13'd1);
            end
            write_reg(ps2m_pkg::CFG_X_LIMIT, phase_x[ph]);
            write_reg(ps2m_pkg::CFG_Y_LIMIT, phase_y[ph]);
            if (ph == 4)
            begin
                // receiver stops while bytes keep coming, block must stall its input
                @(posedge clk);
                hold_requests++;
            end
            send_random_traffic(PHASE_BYTES, bit'(ph % 2), bit'((ph / 2) % 2));
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("** ps2_mouse_packet_decoder: PASSED **");
        else
            $display("** ps2_mouse_packet_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== ps2_mouse_packet_decoder.f =====
sv/ps2m_pkg.sv
sv/ps2m_in_reg.sv
sv/ps2m_core.sv
sv/ps2m_out_reg.sv
sv/ps2_mouse_packet_decoder.sv
tb/sv/ps2_mouse_packet_decoder_checker.sv
tb/sv/ps2_mouse_packet_decoder_test.sv
